/* design/vcm_pkg.sv */
// Package for the vector convergence monitor: payload structs, register
// indexes, widths, the sequencer state type and control struct. No dependencies.
package vcm_pkg;

  localparam int MaxLength = 1024;
  localparam int AddrW = $clog2(MaxLength);
  localparam int LenW = 11;
  localparam int SumW = 44;
  localparam int MagW = 34;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SUCCESSES = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_CHECKS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_LENGTH = 2'd3;

  typedef struct packed {
    logic signed [31:0] elem_real;
    logic signed [31:0] elem_imag;
  } in_item_t;

  typedef struct packed {
    logic [31:0] relative_error;
    logic below_threshold;
    logic converged;
    logic limit_reached;
    logic [15:0] check_number;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SQRT, ST_DIV, ST_DONE
  } state_t;

  // start request from sequencer to the arithmetic units
  typedef struct packed {
    logic sqrt_start;
    logic div_start;
  } ctl_t;

endpackage

/* design/vcm_ram.sv */
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module vcm_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/vcm_sqrt.sv */
// Two bit-serial integer square roots (difference and magnitude) of 68-bit
// sums of squares, one result bit per cycle. Uses vcm_pkg.
module vcm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [67:0]                rad_a,
  input  logic [67:0]                rad_b,
  output logic                       done,
  output logic [vcm_pkg::MagW-1:0]   root_a,
  output logic [vcm_pkg::MagW-1:0]   root_b
);
  // restoring digit-by-digit root: 2 radicand bits per step, 34 steps
  logic [67:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [35:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [34:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [35:0] ta, tb;

  always_comb begin
    ra_nxt = ra_r; rb_nxt = rb_r; pa_nxt = pa_r; pb_nxt = pb_r;
    qa_nxt = qa_r; qb_nxt = qb_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    ta = '0; tb = '0;
    if (start) begin
      ra_nxt = rad_a; rb_nxt = rad_b; pa_nxt = '0; pb_nxt = '0;
      qa_nxt = '0; qb_nxt = '0; cnt_nxt = 6'd33; busy_nxt = 1'b1;
    end else if (busy_r) begin
      pa_nxt = {pa_r[33:0], ra_r[67:66]};
      pb_nxt = {pb_r[33:0], rb_r[67:66]};
      ra_nxt = {ra_r[65:0], 2'b00};
      rb_nxt = {rb_r[65:0], 2'b00};
      ta = {qa_r[33:0], 2'b01};
      tb = {qb_r[33:0], 2'b01};
      if (pa_nxt >= ta) begin
        pa_nxt = pa_nxt - ta; qa_nxt = {qa_r[33:0], 1'b1};
      end else begin
        qa_nxt = {qa_r[33:0], 1'b0};
      end
      if (pb_nxt >= tb) begin
        pb_nxt = pb_nxt - tb; qb_nxt = {qb_r[33:0], 1'b1};
      end else begin
        qb_nxt = {qb_r[33:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    ra_r <= ra_nxt; rb_r <= rb_nxt; pa_r <= pa_nxt; pb_r <= pb_nxt;
    qa_r <= qa_nxt; qb_r <= qb_nxt;
  end

  assign done = done_r;
  assign root_a = qa_r[vcm_pkg::MagW-1:0];
  assign root_b = qb_r[vcm_pkg::MagW-1:0];
endmodule

/* design/vcm_div.sv */
// Restoring divider: floor(num * 2^24 / den), saturated to 32 bits,
// 0xFFFFFFFF when den is zero. One quotient bit per cycle. Uses vcm_pkg.
module vcm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vcm_pkg::SumW-1:0]  num,
  input  logic [vcm_pkg::SumW-1:0]  den,
  output logic                      done,
  output logic [31:0]               quot
);
  localparam int NumW = vcm_pkg::SumW + 24;
  logic [NumW-1:0]          n_r, n_nxt;
  logic [vcm_pkg::SumW:0]   rem_r, rem_nxt, trial;
  logic [vcm_pkg::SumW-1:0] d_r, d_nxt;
  logic [NumW-1:0]          q_r, q_nxt;
  logic [6:0]               cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt, done_r, done_nxt, sat_r, sat_nxt;

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; d_nxt = d_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; sat_nxt = sat_r;
    trial = '0;
    if (start) begin
      n_nxt = {num, 24'd0}; d_nxt = den; rem_nxt = '0; q_nxt = '0;
      cnt_nxt = 7'(NumW - 1); busy_nxt = 1'b1;
      // quotient >= 2^32 iff num >= den << 8; den zero saturates too
      sat_nxt = (den == '0) || ({8'd0, num} >= {den, 8'd0});
    end else if (busy_r) begin
      trial = {rem_r[vcm_pkg::SumW-1:0], n_r[NumW-1]};
      n_nxt = {n_r[NumW-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r}; q_nxt = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial; q_nxt = {q_r[NumW-2:0], 1'b0};
      end
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; d_r <= d_nxt; q_r <= q_nxt; sat_r <= sat_nxt;
  end

  assign done = done_r;
  assign quot = sat_r ? 32'hFFFF_FFFF : q_r[31:0];
endmodule

/* design/vector_convergence_monitor.sv */
// Vector convergence monitor, top level: sequencer, vector store, root and
// divide units. Uses vcm_pkg, vcm_ram, vcm_sqrt, vcm_div.
//
// One element per request is taken, compared with the stored element of the
// previous vector and written back. Between one request and the next, each
// element passes through the store read, the squaring register, 34 steps of
// the bit-serial square root (shared by the difference and magnitude roots,
// run side by side), the write-back and the idle state. After the last
// element of a vector a 68-step divide forms the Q8.24 relative error and
// one result is offered; a result held by the receiver stalls only the next
// vector end. After reset and after each vector_length write, a clearing
// pass zeroes all 1024 entries of the store; no element is accepted during
// it. Configuration writes are taken at any time.
module vector_convergence_monitor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vcm_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vcm_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [vcm_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [vcm_pkg::CfgDataW-1:0]       cfg_data
);
  localparam int AW = vcm_pkg::AddrW;

  vcm_pkg::state_t state_r, state_nxt;
  vcm_pkg::ctl_t   ctl;

  logic [31:0] thr_r;
  logic [15:0] succ_r, maxc_r, streak_r, streak_nxt, chk_r, chk_nxt;
  logic [vcm_pkg::LenW-1:0] len_r;
  logic [AW-1:0] pos_r, pos_nxt, clr_r, clr_nxt;
  logic [vcm_pkg::SumW-1:0] dsum_r, dsum_nxt, msum_r, msum_nxt;
  vcm_pkg::in_item_t elem_r;
  vcm_pkg::out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic len_wr;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic signed [32:0] dre, dim;
  logic [32:0]        adre, adim, amre, amim;
  logic [67:0]        rad_d, rad_m;
  logic               sqrt_done, div_done;
  logic [vcm_pkg::MagW-1:0] root_d, root_m;
  logic [31:0]        quot;
  logic [vcm_pkg::LenW-1:0] len_new;
  logic               last;

  assign len_wr = cfg_we && (cfg_index == vcm_pkg::REG_LENGTH);
  always_comb begin
    len_new = cfg_data[vcm_pkg::LenW-1:0];
    if (len_new == '0) len_new = vcm_pkg::LenW'(1);
    if (len_new > vcm_pkg::LenW'(vcm_pkg::MaxLength))
      len_new = vcm_pkg::LenW'(vcm_pkg::MaxLength);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 32'd16777; succ_r <= 16'd1; maxc_r <= 16'd100;
      len_r <= vcm_pkg::LenW'(vcm_pkg::MaxLength);
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcm_pkg::REG_THRESHOLD:  thr_r <= cfg_data;
        vcm_pkg::REG_SUCCESSES:  succ_r <= cfg_data[15:0];
        vcm_pkg::REG_MAX_CHECKS: maxc_r <= cfg_data[15:0];
        vcm_pkg::REG_LENGTH:     len_r <= len_new;
        default: ;
      endcase
    end
  end

  vcm_ram #(.Width(64), .Depth(vcm_pkg::MaxLength)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(pos_r), .rdata(ram_rdata)
  );

  // squared magnitudes of new - old and of new, |x| fits 33 bits
  always_comb begin
    dre = 33'(elem_r.elem_real) - 33'($signed(ram_rdata[63:32]));
    dim = 33'(elem_r.elem_imag) - 33'($signed(ram_rdata[31:0]));
    adre = dre[32] ? 33'(-dre) : 33'(dre);
    adim = dim[32] ? 33'(-dim) : 33'(dim);
    amre = elem_r.elem_real[31] ? 33'(-33'(elem_r.elem_real)) : 33'(elem_r.elem_real);
    amim = elem_r.elem_imag[31] ? 33'(-33'(elem_r.elem_imag)) : 33'(elem_r.elem_imag);
  end

  logic [67:0] sq_dre_r, sq_dim_r, sq_mre_r, sq_mim_r;
  always_ff @(posedge clk) begin
    sq_dre_r <= 68'(adre * adre); sq_dim_r <= 68'(adim * adim);
    sq_mre_r <= 68'(amre * amre); sq_mim_r <= 68'(amim * amim);
  end
  assign rad_d = sq_dre_r + sq_dim_r;
  assign rad_m = sq_mre_r + sq_mim_r;

  vcm_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(ctl.sqrt_start), .rad_a(rad_d), .rad_b(rad_m),
    .done(sqrt_done), .root_a(root_d), .root_b(root_m)
  );

  vcm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start), .num(dsum_r), .den(msum_r),
    .done(div_done), .quot(quot)
  );

  assign last = ({1'b0, pos_r} + vcm_pkg::LenW'(1)) >= len_r;

  // ST_READ covers the RAM read, then the squares register; a sub flag
  logic rd2_r, rd2_nxt;

  always_comb begin
    state_nxt = state_r; ctl = '0;
    pos_nxt = pos_r; clr_nxt = clr_r; dsum_nxt = dsum_r; msum_nxt = msum_r;
    streak_nxt = streak_r; chk_nxt = chk_r; res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd2_nxt = 1'b0;
    ram_we = 1'b0; ram_waddr = pos_r; ram_wdata = {elem_r.elem_real, elem_r.elem_imag};
    in_ready = 1'b0;
    unique case (state_r)
      vcm_pkg::ST_CLEAR: begin
        ram_we = 1'b1; ram_waddr = clr_r; ram_wdata = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(vcm_pkg::MaxLength - 1)) state_nxt = vcm_pkg::ST_IDLE;
      end
      vcm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = vcm_pkg::ST_READ;
      end
      vcm_pkg::ST_READ: begin
        if (rd2_r) begin
          ctl.sqrt_start = 1'b1; state_nxt = vcm_pkg::ST_SQRT;
        end else begin
          rd2_nxt = 1'b1;
        end
      end
      vcm_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          ram_we = 1'b1;
          dsum_nxt = dsum_r + vcm_pkg::SumW'(root_d);
          msum_nxt = msum_r + vcm_pkg::SumW'(root_m);
          if (last) begin
            state_nxt = vcm_pkg::ST_DIV;
          end else begin
            pos_nxt = pos_r + AW'(1); state_nxt = vcm_pkg::ST_IDLE;
          end
        end
      end
      vcm_pkg::ST_DIV: begin
        // sums settled last cycle; launch once
        if (!rd2_r) begin
          ctl.div_start = 1'b1; rd2_nxt = 1'b1;
        end else begin
          rd2_nxt = 1'b1;
          if (div_done) state_nxt = vcm_pkg::ST_DONE;
        end
      end
      vcm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          res_nxt.relative_error = quot;
          res_nxt.below_threshold = quot < thr_r;
          if (res_nxt.below_threshold) begin
            if (streak_r != 16'hFFFF) streak_nxt = streak_r + 16'd1;
          end else begin
            streak_nxt = '0;
          end
          res_nxt.check_number = chk_r;
          res_nxt.limit_reached = chk_r >= maxc_r;
          res_nxt.converged = (streak_nxt > succ_r) || res_nxt.limit_reached;
          if (chk_r != 16'hFFFF) chk_nxt = chk_r + 16'd1;
          out_valid_nxt = 1'b1;
          dsum_nxt = '0; msum_nxt = '0; pos_nxt = '0;
          state_nxt = vcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vcm_pkg::ST_IDLE;
    endcase
    if (len_wr) begin
      state_nxt = vcm_pkg::ST_CLEAR; clr_nxt = '0;
      dsum_nxt = '0; msum_nxt = '0; pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcm_pkg::ST_CLEAR; clr_r <= '0; pos_r <= '0;
      dsum_r <= '0; msum_r <= '0; streak_r <= '0; chk_r <= 16'd1;
      out_valid_r <= 1'b0; rd2_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; pos_r <= pos_nxt;
      dsum_r <= dsum_nxt; msum_r <= msum_nxt; streak_r <= streak_nxt;
      chk_r <= chk_nxt; out_valid_r <= out_valid_nxt; rd2_r <= rd2_nxt;
    end
    res_r <= res_nxt;
    if (in_ready && in_valid) elem_r <= in_data;
  end

  assign out_valid = out_valid_r;
  assign out_data = res_r;
endmodule

/* design/vcm_checker.sv */
// Port-level checker for the vector convergence monitor, bound to the top
// level. Uses vcm_pkg for the payload types.
module vcm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input vcm_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_conv_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.limit_reached |-> out_data.converged)
    else $error("limit without convergence");

  a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.below_threshold |-> out_data.relative_error != 32'hFFFF_FFFF)
    else $error("saturated error flagged below threshold");

  a_chk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.check_number != 16'd0)
    else $error("check number zero");

  // one element at a time: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");
endmodule

bind vector_convergence_monitor vcm_checker u_vcm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
